// ===== rtl/smbs_pkg.sv =====
// ----------------------------------------------------------------------------
// smbs_pkg
// Shared constants for the sorted-matrix search block: default sizes, field
// widths, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package smbs_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CNT_W = 7;          // row_count / column_count width
  localparam int IDX_W = CNT_W + 1;  // signed search bound width
  localparam int POS_W = 6;          // row_index / column_index width
  localparam int VAL_W = 32;         // entry_value / target width

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

endpackage

// ===== rtl/smbs_ram.sv =====
// ----------------------------------------------------------------------------
// smbs_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module smbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_matrix_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// A search makes at most floor(log2 rows) row probes and at most floor(log2
// columns) + 1 column probes. A row probe reads and compares the first and the
// last entry of the middle row; a column probe is one read of the matrix RAM
// and a compare.
// Throughput: one item at a time; the result register frees the next search.
// Reset: synchronous; clears control state and both counts, not the matrix.
// ----------------------------------------------------------------------------
// sorted_matrix_binary_search_top
// Matrix store with row-then-column binary search over a synchronous RAM.
// ----------------------------------------------------------------------------
module sorted_matrix_binary_search_top import smbs_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic [POS_W-1:0]        row_index,
  input  logic [POS_W-1:0]        column_index,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic signed [VAL_W-1:0] target,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_LOOP,
    S_ROW_FIRST,
    S_ROW_LAST,
    S_COL_LOOP,
    S_COL_CMP,
    S_DONE
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              row_count;
  logic [CNT_W-1:0]              column_count;
  logic [CNT_W-1:0]              n_rows;
  logic [CNT_W-1:0]              n_cols;
  logic signed [DATA_WIDTH-1:0]  tgt;
  logic signed [IDX_W-1:0]       lo;
  logic signed [IDX_W-1:0]       hi;
  logic [CNT_W-1:0]              row_sel;
  logic                          res;

  logic                          in_xfer;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic signed [DATA_WIDTH-1:0]  rd_data;
  logic [IDX_W:0]                mid_sum;
  logic [CNT_W-1:0]              mid;
  logic signed [IDX_W-1:0]       mid_s;
  logic [CNT_W-1:0]              n_rows_next;
  logic [CNT_W-1:0]              n_cols_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  assign n_rows_next = (int'(row_count) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count;
  assign n_cols_next = (int'(column_count) > MAX_COLS) ? CNT_W'(MAX_COLS) : column_count;

  assign mid_sum = {lo[IDX_W-1], lo} + {hi[IDX_W-1], hi};
  assign mid     = mid_sum[IDX_W-1:1];
  assign mid_s   = signed'({1'b0, mid});

  assign wr_en   = in_xfer && (cmd == CMD_WRITE) &&
                   (int'(row_index) < MAX_ROWS) && (int'(column_index) < MAX_COLS);
  assign wr_addr = AW'(int'(row_index) * MAX_COLS + int'(column_index));

  always_comb begin
    case (state)
      S_ROW_FIRST: rd_addr = AW'(int'(mid) * MAX_COLS + int'(n_cols) - 1);
      S_COL_LOOP:  rd_addr = AW'(int'(row_sel) * MAX_COLS + int'(mid));
      default:     rd_addr = AW'(int'(mid) * MAX_COLS);
    endcase
  end

  smbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (DATA_WIDTH'(entry_value)),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_count    <= '0;
      column_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_count    <= cfg_data;
          REG_COLUMN_COUNT: column_count <= cfg_data;
          default:          row_count    <= row_count;
        endcase
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && (cmd == CMD_SEARCH)) begin
            n_rows <= n_rows_next;
            n_cols <= n_cols_next;
            tgt    <= DATA_WIDTH'(target);
            lo     <= '0;
            hi     <= signed'({1'b0, n_rows_next}) - IDX_W'(1);
            if ((n_rows_next == '0) || (n_cols_next == '0)) begin
              res   <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_ROW_LOOP;
            end
          end
        end
        S_ROW_LOOP: begin
          if (lo < hi) begin
            state <= S_ROW_FIRST;
          end else begin
            row_sel <= lo[CNT_W-1:0];
            lo      <= '0;
            hi      <= signed'({1'b0, n_cols}) - IDX_W'(1);
            state   <= S_COL_LOOP;
          end
        end
        S_ROW_FIRST: begin
          if (rd_data > tgt) begin
            hi    <= mid_s - IDX_W'(1);
            state <= S_ROW_LOOP;
          end else begin
            state <= S_ROW_LAST;
          end
        end
        S_ROW_LAST: begin
          if (rd_data < tgt) begin
            lo <= mid_s + IDX_W'(1);
          end else begin
            lo <= mid_s;
            hi <= mid_s;
          end
          state <= S_ROW_LOOP;
        end
        S_COL_LOOP: begin
          if (lo <= hi) begin
            state <= S_COL_CMP;
          end else begin
            res   <= 1'b0;
            state <= S_DONE;
          end
        end
        S_COL_CMP: begin
          if (rd_data == tgt) begin
            res   <= 1'b1;
            state <= S_DONE;
          end else begin
            if (rd_data > tgt) begin
              hi <= mid_s - IDX_W'(1);
            end else begin
              lo <= mid_s + IDX_W'(1);
            end
            state <= S_COL_LOOP;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            found     <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_first_after_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW_FIRST) |-> ($past(state) == S_ROW_LOOP))
    else $error("row probe compare without a read issued");

  a_col_after_loop: assert property (@(posedge clk) disable iff (rst)
    (state == S_COL_CMP) |-> ($past(state) == S_COL_LOOP))
    else $error("column probe compare without a read issued");

  a_row_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW_FIRST) |-> (mid < n_rows))
    else $error("row probe outside the rows in use");

  a_zero_count_miss: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (cmd == CMD_SEARCH) && ((n_rows_next == '0) || (n_cols_next == '0)))
    |=> (state == S_DONE) && !res)
    else $error("search with an empty matrix must miss");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result dropped while output register busy");

endmodule
